/* design/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sha256_pkg;

  localparam int unsigned BlockBytes   = 64;
  localparam int unsigned LengthOffset = 56;
  localparam logic [7:0]  PadMark      = 8'h80;
  localparam int unsigned CountWidth   = 61;
  localparam int unsigned Rounds       = 64;

  typedef enum logic [0:0] {
    REQ_ABSORB = 1'b0,
    REQ_FINISH = 1'b1
  } req_type_t;

  // Byte write source for the block store.
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      wr_byte;     // write one byte at the fill pointer and advance it
    byte_src_t src;
    logic      count_byte;  // count one message byte
    logic      start;       // begin a compression of the block store
    logic      clear;       // return to the initial state
  } sha256_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       busy;       // compression in progress
    logic [5:0] fill;       // fill pointer
  } sha256_sts_t;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[i];
  endfunction

  function automatic word_t initial_h(input logic [2:0] i);
    word_t h [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    return h[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* design/sha256_datapath.sv */
// Block store, message schedule, round unit and chaining words.
module sha256_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha256_pkg::sha256_cmd_t cmd,
  input  logic [7:0]             data_byte,
  output sha256_pkg::sha256_sts_t sts,
  output logic [255:0]           digest
);

  logic [31:0] store_r [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [sha256_pkg::CountWidth-1:0] count_r, count_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  round_r;
  logic        busy_r, busy_nxt;
  logic        fold_r;
  logic [7:0]  wr_data;
  logic [63:0] bits;
  logic [2:0]  len_idx;
  logic [31:0] s0, s1, w_new, wt, t1, t2;
  logic [31:0] e, a;
  logic [31:0] last_word;

  assign bits    = {count_r, 3'b000};
  assign len_idx = fill_r[2:0];

  always_comb begin
    unique case (cmd.src)
      sha256_pkg::SRC_DATA: wr_data = data_byte;
      sha256_pkg::SRC_PAD:  wr_data = sha256_pkg::PadMark;
      sha256_pkg::SRC_ZERO: wr_data = 8'h00;
      sha256_pkg::SRC_LEN:  wr_data = bits[(7 - len_idx) * 8 +: 8];
      default:              wr_data = 8'h00;
    endcase
  end

  // Every start comes with the write of byte 63, so that byte is merged in on the load.
  assign last_word = {store_r[15][31:8], wr_data};

  // The schedule window is a 16-word shift line; w_r[0] is the word of this round.
  assign wt = w_r[0];
  assign s0 = sha256_pkg::rotr(w_r[1], 7) ^ sha256_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = sha256_pkg::rotr(w_r[14], 17) ^ sha256_pkg::rotr(w_r[14], 19)
            ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + s0 + w_r[9] + s1;

  assign e  = v_r[4];
  assign a  = v_r[0];
  assign t1 = v_r[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
            ^ sha256_pkg::rotr(e, 25)) + ((e & v_r[5]) ^ (~e & v_r[6]))
            + sha256_pkg::round_k(round_r) + wt;
  assign t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    fill_nxt  = cmd.wr_byte ? fill_r + 6'd1 : fill_r;
    count_nxt = cmd.count_byte ? count_r + 1'b1 : count_r;
    busy_nxt  = busy_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && round_r == 6'd63) begin
      busy_nxt = 1'b0;
    end
    if (cmd.clear) begin
      fill_nxt  = '0;
      count_nxt = '0;
    end
  end

  // Bytes are stored big-endian within each word, byte 4*i in the top lane.
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      store_r[fill_r[5:2]][(3 - fill_r[1:0]) * 8 +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      count_r <= '0;
      busy_r  <= 1'b0;
      fold_r  <= 1'b0;
      round_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::initial_h(3'(i));
    end else begin
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      fold_r  <= busy_r && round_r == 6'd63;
      if (cmd.start) begin
        round_r <= '0;
      end else if (busy_r) begin
        round_r <= round_r + 6'd1;
      end
      if (cmd.clear) begin
        for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::initial_h(3'(i));
      end else if (fold_r) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      for (int i = 0; i < 15; i++) w_r[i] <= store_r[i];
      w_r[15] <= last_word;
    end else if (busy_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= e;
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= a;
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
  end

  assign sts.busy = busy_r | fold_r;
  assign sts.fill = fill_r;
  assign digest = {h_r[7], h_r[6], h_r[5], h_r[4], h_r[3], h_r[2], h_r[1], h_r[0]};

endmodule

/* design/sha256_ctrl.sv */
// Request sequencer: intake, padding, compression start and digest hand-off.
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic                    in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [255:0]            digest,
  output logic [255:0]            out_tdata,
  output sha256_pkg::sha256_cmd_t cmd,
  input  sha256_pkg::sha256_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WAIT, ST_PAD_FILL, ST_PAD_ZERO, ST_PAD_LEN, ST_LAST, ST_EMIT
  } state_t;

  state_t       state_r;
  logic         out_valid_r;
  logic [255:0] out_data_r;
  logic         accept;

  assign in_tready  = state_r == ST_IDLE && !sts.busy;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.wr_byte = 1'b1;
          if (in_tuser == sha256_pkg::REQ_ABSORB) begin
            cmd.src        = sha256_pkg::SRC_DATA;
            cmd.count_byte = 1'b1;
            cmd.start      = sts.fill == 6'd63;
          end else begin
            cmd.src = sha256_pkg::SRC_PAD;
            cmd.start = sts.fill == 6'd63;
          end
        end
      end
      ST_PAD_FILL: begin
        // Length does not fit behind the mark: zero out this block and compress it.
        cmd.wr_byte = 1'b1;
        cmd.src     = sha256_pkg::SRC_ZERO;
        cmd.start   = sts.fill == 6'd63;
      end
      ST_PAD_ZERO: begin
        if (!sts.busy && sts.fill != 6'(sha256_pkg::LengthOffset)) begin
          cmd.wr_byte = 1'b1;
          cmd.src     = sha256_pkg::SRC_ZERO;
        end
      end
      ST_PAD_LEN: begin
        cmd.wr_byte = 1'b1;
        cmd.src     = sha256_pkg::SRC_LEN;
        cmd.start   = sts.fill == 6'd63;
      end
      ST_EMIT: begin
        cmd.clear = !out_valid_r || out_tready;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (state_r == ST_EMIT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= digest;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_tuser == sha256_pkg::REQ_FINISH) begin
            if (sts.fill == 6'd63) begin
              state_r <= ST_PAD_ZERO;
            end else if (sts.fill >= 6'(sha256_pkg::LengthOffset)) begin
              state_r <= ST_PAD_FILL;
            end else begin
              state_r <= ST_PAD_ZERO;
            end
          end
        end
        ST_PAD_FILL: if (sts.fill == 6'd63) state_r <= ST_PAD_ZERO;
        ST_PAD_ZERO: begin
          if (!sts.busy && sts.fill == 6'(sha256_pkg::LengthOffset)) state_r <= ST_PAD_LEN;
        end
        ST_PAD_LEN: if (sts.fill == 6'd63) state_r <= ST_LAST;
        ST_LAST: if (!sts.busy) state_r <= ST_EMIT;
        ST_EMIT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/sha256_byte_stream_hasher_top.sv */
// Top level of the SHA-256 byte stream hasher.
//   channel  dir  payload
//   in_*     in   tdata = data_byte[7:0]; tuser = req_type
//   out_*    out  tdata = digest_word_0 .. digest_word_7, 32 bits each
// The 64th byte of a block starts a compression of 64 rounds and a fold into
// the chaining words, one round per cycle in the shared round unit, during
// which no request is taken. A finish request writes padding one byte a cycle
// while no compression is running, and runs one or two compressions.
// Reset (rst_n low, synchronous) restores the initial hash.
// The digest sits in an output register; a stalled out_tready holds it.
module sha256_byte_stream_hasher_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // digest_word_0 .. digest_word_7
);

  sha256_pkg::sha256_cmd_t cmd;
  sha256_pkg::sha256_sts_t sts;
  logic [255:0]            digest;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser,
    .out_tvalid, .out_tready, .digest, .out_tdata, .cmd, .sts
  );

  sha256_datapath u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_tdata), .sts, .digest
  );

endmodule

/* design/sha256_checker.sv */
// Port-level checks for the hasher, bound to the top level.
module sha256_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [255:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("digest dropped while stalled");

  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("request taken right after finish");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .out_tvalid, .out_tready, .out_tdata
);

/* bench/tb_sha256_byte_stream_hasher_top.sv */
// Self-checking testbench for the SHA-256 byte stream hasher with a built-in digest predictor.
module tb_sha256_byte_stream_hasher_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;

  sha256_byte_stream_hasher_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic [31:0]  hash_h [8];
  logic [7:0]   msg_block [64];
  int unsigned  msg_fill;
  logic [60:0]  msg_len;

  logic [255:0] digest_queue [$];
  int           error_count = 0;
  int           digest_count = 0;
  int           stall_hold = 0;   // cycles the receiver must hold off
  int           max_gap_in = 3;   // long gaps enabled when nonzero

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void reset_hash();
    hash_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    msg_fill = 0;
    msg_len = '0;
  endfunction

  function automatic void compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(i[5:0]) + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endfunction

  // Applies one accepted request to the predictor; a finish queues a digest.
  function automatic void predict_digest(input sha256_pkg::req_type_t kind,
                                         input logic [7:0] b);
    logic [63:0]  bits;
    logic [255:0] d;
    if (kind == sha256_pkg::REQ_ABSORB) begin
      msg_block[msg_fill] = b;
      msg_len++;
      msg_fill = (msg_fill + 1) % 64;
      if (msg_fill == 0) compress_msg_block();
      return;
    end
    bits = {msg_len, 3'b000};
    msg_block[msg_fill] = sha256_pkg::PadMark;
    msg_fill++;
    if (msg_fill > sha256_pkg::LengthOffset) begin
      while (msg_fill < sha256_pkg::BlockBytes) msg_block[msg_fill++] = 8'h00;
      compress_msg_block();
      msg_fill = 0;
    end
    while (msg_fill < sha256_pkg::LengthOffset) msg_block[msg_fill++] = 8'h00;
    for (int i = 0; i < 8; i++) msg_block[sha256_pkg::LengthOffset + i] = bits[63 - 8*i -: 8];
    compress_msg_block();
    for (int i = 0; i < 8; i++) d[32*i +: 32] = hash_h[i];
    digest_queue.push_back(d);
    reset_hash();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return max_gap_in ? $urandom_range(10, 60) : 0;
  endfunction

  // Leaves in_tvalid high after the accepting edge; a gap before the next
  // request or the end of the run drops it.
  task automatic send_request(input sha256_pkg::req_type_t kind, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_digest(kind, b);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_request(sha256_pkg::REQ_ABSORB, 8'($urandom));
    send_request(sha256_pkg::REQ_FINISH, 8'($urandom));
  endtask

  // Result checker.
  always @(posedge clk) begin
    logic [255:0] exp_d;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        digest_count++;
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest %h", $time, out_tdata);
          error_count++;
        end else begin
          exp_d = digest_queue.pop_front();
          for (int i = 0; i < 8; i++)
            if (exp_d[32*i +: 32] !== out_tdata[32*i +: 32]) begin
              $display("%0t: digest_word_%0d expected %h actual %h", $time, i,
                       exp_d[32*i +: 32], out_tdata[32*i +: 32]);
              error_count++;
            end
        end
      end
    end
  end

  // Receiver back-pressure with occasional long hold-offs.
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) < 70) ||
                      (($urandom_range(0, 99) < 3) ? 1'b0 : 1'b0);
        if ($urandom_range(0, 199) == 0) stall_hold <= $urandom_range(20, 150);
      end
    end
  end

  task automatic test_directed();
    send_request(sha256_pkg::REQ_FINISH, 8'h00);             // empty message
    send_request(sha256_pkg::REQ_ABSORB, 8'h61);              // "abc"
    send_request(sha256_pkg::REQ_ABSORB, 8'h62);
    send_request(sha256_pkg::REQ_ABSORB, 8'h63);
    send_request(sha256_pkg::REQ_FINISH, 8'hFF);
    send_request(sha256_pkg::REQ_ABSORB, 8'h00);
    send_request(sha256_pkg::REQ_ABSORB, 8'hFF);
    send_request(sha256_pkg::REQ_ABSORB, 8'hAA);
    send_request(sha256_pkg::REQ_ABSORB, 8'h55);
    send_request(sha256_pkg::REQ_FINISH, 8'h5A);
  endtask

  // Lengths around the padding boundaries: 55 fits one block, 56..63 need two.
  task automatic test_pad_boundaries();
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
  endtask

  // Receiver holds off while several short messages are offered.
  task automatic test_backpressure();
    stall_hold = 400;
    for (int i = 0; i < 4; i++) send_message($urandom_range(0, 3));
  endtask

  task automatic test_random_messages();
    int sent;
    int len;
    sent = 0;
    while (sent < 1050 - 270) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      if ($urandom_range(0, 5) == 0) max_gap_in = 0; else max_gap_in = 3;
      send_message(len);
      sent += len + 1;
    end
    max_gap_in = 3;
  endtask

  initial begin
    reset_hash();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pad_boundaries();
    test_backpressure();
    test_random_messages();
    in_tvalid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered empty, short, padding-boundary and multi-block messages;");
    $display("%0d digests checked under random gaps and receiver stalls.", digest_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
